/* rtl/tpg_pkg.sv */
// Package for the CRC-16 framed test packet generator.
// Holds constants, the CRC byte step and the controller/datapath interface types.
// No dependencies.
package tpg_pkg;

	localparam logic [7:0]  SYNC_A           = 8'h51;
	localparam logic [7:0]  SYNC_B           = 8'h55;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'h1021;
	localparam logic [15:0] CRC_TOP          = 16'h8000;
	localparam logic [7:0]  MIN_PACKET_BYTES = 8'd10;
	localparam logic [7:0]  CAPACITY_RESET   = 8'd128;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture a request word
		logic step;   // produce the next result word into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;   // the word about to be produced ends the packet
	} sts_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] acc;
		acc = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if ((acc & CRC_TOP) != 16'h0000) begin
				acc = {acc[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				acc = {acc[14:0], 1'b0};
			end
		end
		return acc;
	endfunction

endpackage

/* rtl/test_packet_generator_crc16_top.sv */
// Framed test packet generator with CRC-16/CCITT-FALSE trailer.
// An accepted request is held in the request registers; in S_RUN the controller
// steps each result word into the output register whenever that register is free;
// a packet of L bytes is ceil(L/2) words, one word of two bytes per cycle while
// not stalled. A rejected request is one word. Requests are taken one at a time.
// Reset: arst_n clears the controller and output valid, capacity returns to 128.
module test_packet_generator_crc16_top #(
	parameter int MAX_PACKET_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: buffer capacity register
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  port_id,
	input  logic [31:0] sequence_req,
	input  logic [7:0]  packet_length,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_first,
	output logic [7:0]  byte_second,
	output logic [1:0]  byte_count,
	output logic        last,
	output logic        rejected
);

	tpg_pkg::cmd_t cmd;
	tpg_pkg::sts_t sts;

	// Controller: idle until a request word arrives, then step the datapath
	// whenever the output register is empty or being drained.
	tpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: builds each byte pair from the held request, folds body bytes
	// into the CRC on the fly, and emits the CRC trailer low byte first.
	tpg_datapath #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.port_id       (port_id),
		.sequence_req  (sequence_req),
		.packet_length (packet_length),
		.cmd           (cmd),
		.sts           (sts),
		.byte_first    (byte_first),
		.byte_second   (byte_second),
		.byte_count    (byte_count),
		.last          (last),
		.rejected      (rejected)
	);

endmodule

/* rtl/tpg_ctrl.sv */
// Controller state machine of the test packet generator.
// Depends on tpg_pkg for state, command and status types.
module tpg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  tpg_pkg::sts_t sts,
	output tpg_pkg::cmd_t cmd
);

	tpg_pkg::state_t state_q;
	tpg_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == tpg_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.step = (state_q == tpg_pkg::S_RUN) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tpg_pkg::S_IDLE: begin
				if (cmd.load) begin
					state_d = tpg_pkg::S_RUN;
				end
			end
			tpg_pkg::S_RUN: begin
				if (cmd.step && sts.last) begin
					state_d = tpg_pkg::S_IDLE;
				end
			end
			default: state_d = tpg_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpg_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/tpg_datapath.sv */
// Datapath of the test packet generator: request registers, byte position,
// running CRC, capacity register and output register. Depends on tpg_pkg.
module tpg_datapath #(
	parameter int MAX_PACKET_BYTES = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic [7:0]    port_id,
	input  logic [31:0]   sequence_req,
	input  logic [7:0]    packet_length,
	input  tpg_pkg::cmd_t cmd,
	output tpg_pkg::sts_t sts,
	output logic [7:0]    byte_first,
	output logic [7:0]    byte_second,
	output logic [1:0]    byte_count,
	output logic          last,
	output logic          rejected
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PACKET_BYTES);

	logic [7:0]  capacity_q;
	logic [7:0]  port_q;
	logic [31:0] seq_q;
	logic [7:0]  len_q;
	logic        reject_q;
	logic [7:0]  pos_q;
	logic [15:0] crc_q;

	logic [8:0]  pos0;
	logic [8:0]  pos1;
	logic [8:0]  len9;
	logic [8:0]  body9;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [15:0] c1;
	logic [15:0] c2;
	logic [7:0]  first_d;
	logic [7:0]  second_d;
	logic        pair_d;
	logic        last_d;

	function automatic logic [7:0] gen_byte(input logic [7:0] idx, input logic [7:0] port,
			input logic [31:0] seq, input logic [7:0] len);
		logic [7:0] v;
		unique case (idx)
			8'd0:    v = tpg_pkg::SYNC_A;
			8'd1:    v = tpg_pkg::SYNC_B;
			8'd2:    v = port;
			8'd3:    v = seq[7:0];
			8'd4:    v = seq[15:8];
			8'd5:    v = seq[23:16];
			8'd6:    v = seq[31:24];
			8'd7:    v = len;
			default: v = port ^ seq[7:0] ^ idx;
		endcase
		return v;
	endfunction

	assign pos0  = {1'b0, pos_q};
	assign pos1  = pos0 + 9'd1;
	assign len9  = {1'b0, len_q};
	assign body9 = len9 - 9'd2;

	assign b0 = gen_byte(pos0[7:0], port_q, seq_q, len_q);
	assign b1 = gen_byte(pos1[7:0], port_q, seq_q, len_q);

	// fold body bytes of this pair into the CRC, skip trailer positions
	assign c1 = (pos0 < body9) ? tpg_pkg::crc_byte(crc_q, b0) : crc_q;
	assign c2 = (pos1 < body9) ? tpg_pkg::crc_byte(c1, b1) : c1;

	always_comb begin
		if (pos0 < body9) begin
			first_d = b0;
		end else if (pos0 == body9) begin
			first_d = c1[7:0];
		end else begin
			first_d = c1[15:8];
		end
		pair_d = pos1 < len9;
		if (!pair_d) begin
			second_d = 8'h00;
		end else if (pos1 < body9) begin
			second_d = b1;
		end else if (pos1 == body9) begin
			second_d = c2[7:0];
		end else begin
			second_d = c2[15:8];
		end
		last_d = reject_q || ((pos0 + 9'd2) >= len9);
	end

	assign sts.last = last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= tpg_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			port_q   <= port_id;
			seq_q    <= sequence_req;
			len_q    <= packet_length;
			reject_q <= (packet_length < tpg_pkg::MIN_PACKET_BYTES) ||
			            (packet_length > MAX_LEN) || (packet_length > capacity_q);
			pos_q    <= 8'd0;
			crc_q    <= tpg_pkg::CRC_INIT;
		end else if (cmd.step) begin
			pos_q <= pos_q + 8'd2;
			crc_q <= c2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (reject_q) begin
				byte_first  <= 8'h00;
				byte_second <= 8'h00;
				byte_count  <= 2'd0;
				last        <= 1'b1;
				rejected    <= 1'b1;
			end else begin
				byte_first  <= first_d;
				byte_second <= second_d;
				byte_count  <= pair_d ? 2'd2 : 2'd1;
				last        <= last_d;
				rejected    <= 1'b0;
			end
		end
	end

endmodule

/* rtl/tpg_checker.sv */
// Port-level checker for the test packet generator, bound to the top level.
// Depends only on the top level's ports.
module tpg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_first,
	input logic [1:0] byte_count,
	input logic       last,
	input logic       rejected
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_first) && $stable(byte_count))
		else $error("stalled result word changed");

	// a rejection is a single closing word with no bytes
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> last && (byte_count == 2'd0))
		else $error("rejected word malformed");

	// a packet word carries one or two bytes
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rejected |-> (byte_count == 2'd1) || (byte_count == 2'd2))
		else $error("bad byte count");

	// a request is worked alone: no new request right after one is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

endmodule

bind test_packet_generator_crc16_top tpg_checker u_tpg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.byte_first (byte_first),
	.byte_count (byte_count),
	.last       (last),
	.rejected   (rejected)
);

/* test/test_packet_generator_crc16_top_tb.sv */
// Testbench for test_packet_generator_crc16_top: drives packet requests, predicts every
// output word (framing, filler, CRC-16/CCITT-FALSE trailer, rejects) and checks them.
// Depends on rtl/tpg_pkg.sv and rtl/test_packet_generator_crc16_top.sv.
`timescale 1ns / 1ps

module test_packet_generator_crc16_top_tb;

	localparam int PKT_MAX         = 128;
	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 20;
	localparam int RANDOM_PHASES   = 7;
	localparam int PHASE_ITEMS     = 47;

	// One request word as the sender presents it.
	typedef struct {
		logic [7:0]  port;
		logic [31:0] seq;
		logic [7:0]  len;
	} packet_request_t;

	// One output word: up to two packet bytes plus framing flags.
	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [1:0] count;
		logic       last_flag;
		logic       rej;
	} packet_word_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [7:0]  cfg_wdata     = 8'd0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [7:0]  port_id       = 8'd0;
	logic [31:0] sequence_req  = 32'd0;
	logic [7:0]  packet_length = 8'd0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [7:0]  byte_first;
	logic [7:0]  byte_second;
	logic [1:0]  byte_count;
	logic        last;
	logic        rejected;

	// Requests waiting for the driver, and packet words still owed by the block.
	packet_request_t request_queue[$];
	packet_word_t    packet_words_due[$];

	// Mirror of the capacity register, written only while the block is idle.
	logic [7:0] capacity_model = tpg_pkg::CAPACITY_RESET;

	// Idle percentages for each side; the stimulus block changes them per phase.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int mismatch_count = 0;
	int words_seen     = 0;
	int cycle_count    = 0;

	test_packet_generator_crc16_top #(
		.MAX_PACKET_BYTES(PKT_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.port_id      (port_id),
		.sequence_req (sequence_req),
		.packet_length(packet_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_first   (byte_first),
		.byte_second  (byte_second),
		.byte_count   (byte_count),
		.last         (last),
		.rejected     (rejected)
	);

	always #HALF_PERIOD clk = ~clk;

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch at word %0d: %s got 0x%0h want 0x%0h",
			words_seen, what, got, want);
	endtask

	// Build the whole packet for one accepted request and queue its words.
	// Out-of-range lengths (too short, over the parameter limit or over the
	// programmed capacity) collapse into a single rejected word.
	function automatic void predict_packet_words(input logic [7:0] port,
			input logic [31:0] seq, input logic [7:0] len);
		logic [7:0]   pkt_bytes [0:255];
		logic [15:0]  crc;
		packet_word_t word;
		int           body;
		int           n_words;
		int           pos;
		if (len < tpg_pkg::MIN_PACKET_BYTES || int'(len) > PKT_MAX || len > capacity_model) begin
			word = '{first: 8'd0, second: 8'd0, count: 2'd0, last_flag: 1'b1, rej: 1'b1};
			packet_words_due.push_back(word);
			return;
		end
		pkt_bytes[0] = tpg_pkg::SYNC_A;
		pkt_bytes[1] = tpg_pkg::SYNC_B;
		pkt_bytes[2] = port;
		pkt_bytes[3] = seq[7:0];
		pkt_bytes[4] = seq[15:8];
		pkt_bytes[5] = seq[23:16];
		pkt_bytes[6] = seq[31:24];
		pkt_bytes[7] = len;
		body = int'(len) - 2;
		// Filler mixes the port, the low sequence byte and the byte position.
		for (int k = 8; k < body; k++) begin
			pkt_bytes[k] = port ^ seq[7:0] ^ 8'(k);
		end
		// CRC-16/CCITT-FALSE, MSB first, over header and filler.
		crc = tpg_pkg::CRC_INIT;
		for (int k = 0; k < body; k++) begin
			crc = crc ^ {pkt_bytes[k], 8'h00};
			for (int b = 0; b < 8; b++) begin
				crc = crc[15] ? ({crc[14:0], 1'b0} ^ tpg_pkg::CRC_POLY) : {crc[14:0], 1'b0};
			end
		end
		// Trailer goes out low byte first.
		pkt_bytes[body]     = crc[7:0];
		pkt_bytes[body + 1] = crc[15:8];
		n_words = (int'(len) + 1) / 2;
		for (int k = 0; k < n_words; k++) begin
			pos = 2 * k;
			word.first     = pkt_bytes[pos];
			word.second    = (pos + 1 < int'(len)) ? pkt_bytes[pos + 1] : 8'd0;
			word.count     = (pos + 1 < int'(len)) ? 2'd2 : 2'd1;
			word.last_flag = (k + 1 == n_words);
			word.rej       = 1'b0;
			packet_words_due.push_back(word);
		end
	endfunction

	// Request driver: predict on acceptance, then launch the next word or idle.
	always @(posedge clk) begin : request_driver
		packet_request_t req;
		logic            launch;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			launch = 1'b0;
			if (in_valid && in_ready) begin
				predict_packet_words(port_id, sequence_req, packet_length);
			end
			if (!in_valid || in_ready) begin
				// Slot is free: take the next request unless this cycle idles.
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req           = request_queue.pop_front();
					port_id       <= req.port;
					sequence_req  <= req.seq;
					packet_length <= req.len;
					launch        = 1'b1;
				end
			end else begin
				// Hold the word until the block takes it.
				launch = 1'b1;
			end
			in_valid <= launch;
		end
	end

	// Output monitor: compare each accepted word with the oldest expectation.
	always @(posedge clk) begin : word_monitor
		packet_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (packet_words_due.size() == 0) begin
					report_mismatch("unexpected word, byte_first", 32'(byte_first), 32'd0);
				end else begin
					want = packet_words_due.pop_front();
					if (byte_first !== want.first)
						report_mismatch("byte_first", 32'(byte_first), 32'(want.first));
					if (byte_second !== want.second)
						report_mismatch("byte_second", 32'(byte_second), 32'(want.second));
					if (byte_count !== want.count)
						report_mismatch("byte_count", 32'(byte_count), 32'(want.count));
					if (last !== want.last_flag)
						report_mismatch("last", 32'(last), 32'(want.last_flag));
					if (rejected !== want.rej)
						report_mismatch("rejected", 32'(rejected), 32'(want.rej));
				end
				words_seen++;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due",
				cycle_count, packet_words_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_request(input logic [7:0] port, input logic [31:0] seq,
			input logic [7:0] len);
		packet_request_t req;
		req = '{port: port, seq: seq, len: len};
		request_queue.push_back(req);
	endtask

	// Wait until every request is taken and every owed word has come back.
	// Sample on the falling edge so the driver's updates have settled.
	task automatic wait_for_drain();
		while (request_queue.size() != 0 || in_valid || packet_words_due.size() != 0)
			@(negedge clk);
	endtask

	// Program the capacity register; only called once the block has drained.
	task automatic write_capacity(input logic [7:0] value);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we         <= 1'b0;
		capacity_model = value;
	endtask

	// Pick a length: mostly short legal packets, some full-size ones, and a share
	// of too-short, too-long and capacity-boundary lengths.
	function automatic logic [7:0] pick_length(input logic [7:0] cap);
		int lim;
		int hi;
		int r;
		lim = (int'(cap) < PKT_MAX) ? int'(cap) : PKT_MAX;
		hi  = (lim < 10) ? 24 : ((lim < 24) ? lim : 24);
		r   = $urandom_range(99);
		if (r < 55)
			return 8'($urandom_range(hi, 10));
		else if (r < 70)
			return 8'($urandom_range(PKT_MAX, 10));
		else if (r < 80)
			return 8'($urandom_range(255, PKT_MAX + 1));
		else if (r < 88)
			return 8'($urandom_range(9, 0));
		else if (r < 94)
			return cap;
		else
			return 8'(int'(cap) + 1);
	endfunction

	initial begin : stimulus
		logic [7:0] cap_setting;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// First idling mode: sender sparse, receiver very sparse.
		send_idle_pct = 36;
		recv_idle_pct = 88;

		// Directed words at reset capacity: minimum and maximum lengths, odd and
		// even lengths, lengths below the minimum and above the parameter limit.
		queue_request(8'h00, 32'h0000_0000, 8'd10);
		queue_request(8'hFF, 32'hFFFF_FFFF, 8'd11);
		queue_request(8'hA5, 32'h1234_5678, 8'd128);
		queue_request(8'h5A, 32'h8765_4321, 8'd127);
		queue_request(8'h3C, 32'h0000_00FF, 8'd9);
		queue_request(8'hC3, 32'hDEAD_BEEF, 8'd0);
		queue_request(8'h01, 32'h8000_0001, 8'd129);
		queue_request(8'h80, 32'h7FFF_FFFE, 8'd255);
		// Port equal to the low sequence byte: filler reduces to the position.
		queue_request(8'hFF, 32'h0000_00FF, 8'd12);
		queue_request(8'h0F, 32'hF0F0_F00F, 8'd13);
		// Hold off the sender until every owed word is back.
		wait_for_drain();
		queue_request(8'h96, 32'h0102_0304, 8'd64);
		queue_request(8'h69, 32'hAAAA_5555, 8'd65);
		queue_request(8'h00, 32'hFFFF_FF00, 8'd14);
		queue_request(8'h7E, 32'h5555_AAAA, 8'd100);
		for (int k = 0; k < 6; k++)
			queue_request(8'($urandom_range(255)), $urandom, pick_length(capacity_model));
		wait_for_drain();

		// Random phases, each at its own capacity; 255 checks that the parameter
		// limit still rejects long packets, 0 rejects everything.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p >= 5) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (p >= 2) begin
				send_idle_pct = 88;
				recv_idle_pct = 36;
			end
			case (p)
				0:       cap_setting = 8'd255;
				1:       cap_setting = 8'd0;
				2:       cap_setting = 8'd10;
				3:       cap_setting = 8'd11;
				4:       cap_setting = 8'($urandom_range(127, 12));
				5:       cap_setting = 8'd127;
				default: cap_setting = tpg_pkg::CAPACITY_RESET;
			endcase
			write_capacity(cap_setting);
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_request(8'($urandom_range(255)), $urandom, pick_length(capacity_model));
			wait_for_drain();
		end

		// Let any stray words surface before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/tpg_pkg.sv
rtl/tpg_ctrl.sv
rtl/tpg_datapath.sv
rtl/test_packet_generator_crc16_top.sv
rtl/tpg_checker.sv
test/test_packet_generator_crc16_top_tb.sv
